// ===== rtl/core/scr_pkg.sv =====
`default_nettype none
package scr_pkg;

   localparam int unsigned FIX_W      = 32;
   localparam int unsigned RAD_W      = 31;
   localparam int unsigned DIFF_W     = 33;
   localparam int unsigned LEN2_W     = 64;
   localparam int unsigned DEN2_W     = 62;
   localparam int unsigned ROOT_W     = 32;
   localparam int unsigned QUO_W      = 33;
   localparam int unsigned FDM_W      = 63;
   localparam int unsigned NPROD_W    = 94;
   localparam int unsigned APROD_W    = 62;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned SQRT_LAT   = LEN2_W / 2 + 1;
   localparam int unsigned DIV_LAT    = QUO_W + 2;

   localparam logic [RAD_W-1:0] RADIUS_RESET = 31'd65536;

   localparam logic [CSR_ADDR_W-1:0] CSR_CENTER_X = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CENTER_Y = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CENTER_Z = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RADIUS   = 3'd3;

   // carried alongside the square root
   typedef struct packed {
      logic [2:0][FIX_W-1:0] p;
      logic [2:0][FIX_W-1:0] f;
      logic [2:0][FIX_W-1:0] o;
      logic [2:0][RAD_W-1:0] mag;
      logic [2:0]            dneg;
      logic [FDM_W-1:0]      fdm;
      logic                  fdneg;
      logic                  in_sphere;
      logic                  zero;
      logic [DEN2_W-1:0]     len2;
   } sb_sqrt_type;

   // carried alongside the dividers
   typedef struct packed {
      logic [2:0][FIX_W-1:0] p;
      logic [2:0][FIX_W-1:0] f;
      logic [2:0][FIX_W-1:0] o;
      logic [2:0]            dneg;
      logic                  fdneg;
      logic                  in_sphere;
      logic                  zero;
   } sb_div_type;

endpackage
`default_nettype wire

// ===== rtl/core/sphere_collision_response.sv =====
// Pushes a particle that lies strictly inside a sphere out to its surface and strips the
// normal part of its force; at the center it keeps position and force; otherwise it passes
// the position and restores the original force. All values are signed Q16.16, results
// saturate. One particle is taken per clock while req_stall is low. A particle passes
// five stages for offset, products and sums, 33 for the bit-per-stage square root, two
// multiply stages, 35 for the restoring dividers (one quotient bit per stage), and the
// output register. A two-entry output buffer lets the block still take a particle as
// rsp_stall rises. Configuration must be written while no particle is in flight.
`default_nettype none
module sphere_collision_response (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [scr_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [scr_pkg::FIX_W-1:0]        csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [scr_pkg::FIX_W-1:0] req_pos_x,
   input  logic signed [scr_pkg::FIX_W-1:0] req_pos_y,
   input  logic signed [scr_pkg::FIX_W-1:0] req_pos_z,
   input  logic signed [scr_pkg::FIX_W-1:0] req_force_x,
   input  logic signed [scr_pkg::FIX_W-1:0] req_force_y,
   input  logic signed [scr_pkg::FIX_W-1:0] req_force_z,
   input  logic signed [scr_pkg::FIX_W-1:0] req_orig_force_x,
   input  logic signed [scr_pkg::FIX_W-1:0] req_orig_force_y,
   input  logic signed [scr_pkg::FIX_W-1:0] req_orig_force_z,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [scr_pkg::FIX_W-1:0] rsp_new_pos_x,
   output logic signed [scr_pkg::FIX_W-1:0] rsp_new_pos_y,
   output logic signed [scr_pkg::FIX_W-1:0] rsp_new_pos_z,
   output logic signed [scr_pkg::FIX_W-1:0] rsp_new_force_x,
   output logic signed [scr_pkg::FIX_W-1:0] rsp_new_force_y,
   output logic signed [scr_pkg::FIX_W-1:0] rsp_new_force_z,
   output logic                             rsp_hit
);

   localparam int unsigned FW = scr_pkg::FIX_W;
   localparam int unsigned RW = scr_pkg::RAD_W;
   localparam int unsigned SL = scr_pkg::SQRT_LAT;
   localparam int unsigned DL = scr_pkg::DIV_LAT;
   localparam int unsigned QW = scr_pkg::QUO_W;

   typedef struct packed {
      logic [2:0][FW-1:0] pos;
      logic [2:0][FW-1:0] frc;
      logic               hit;
   } res_type;

   function automatic logic [FW-1:0] sat36(input logic signed [35:0] v);
      if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
         sat36 = v[FW-1:0];
      end else if (v[35]) begin
         sat36 = 32'h8000_0000;
      end else begin
         sat36 = 32'h7FFF_FFFF;
      end
   endfunction

   // configuration
   logic signed [FW-1:0] cen_ff [3];
   logic [RW-1:0]        rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cen_ff[0] <= '0;
         cen_ff[1] <= '0;
         cen_ff[2] <= '0;
         rad_ff    <= scr_pkg::RADIUS_RESET;
      end else if (csr_wr_en) begin
         case (csr_addr)
            scr_pkg::CSR_CENTER_X: cen_ff[0] <= csr_wdata;
            scr_pkg::CSR_CENTER_Y: cen_ff[1] <= csr_wdata;
            scr_pkg::CSR_CENTER_Z: cen_ff[2] <= csr_wdata;
            scr_pkg::CSR_RADIUS:   rad_ff    <= csr_wdata[RW-1:0];
            default: ;
         endcase
      end
   end

   logic en;
   logic skid_v_ff;
   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;

   logic signed [FW-1:0] in_p [3];
   logic signed [FW-1:0] in_f [3];
   logic signed [FW-1:0] in_o [3];
   assign in_p[0] = req_pos_x;
   assign in_p[1] = req_pos_y;
   assign in_p[2] = req_pos_z;
   assign in_f[0] = req_force_x;
   assign in_f[1] = req_force_y;
   assign in_f[2] = req_force_z;
   assign in_o[0] = req_orig_force_x;
   assign in_o[1] = req_orig_force_y;
   assign in_o[2] = req_orig_force_z;

   // S1: offset from center
   logic                 s1_v_ff;
   logic signed [FW-1:0] s1_p_ff [3];
   logic signed [FW-1:0] s1_f_ff [3];
   logic signed [FW-1:0] s1_o_ff [3];
   logic signed [32:0]   s1_d_ff [3];

   // S2: magnitude, sign, near test
   logic                 s2_v_ff;
   logic signed [FW-1:0] s2_p_ff [3];
   logic signed [FW-1:0] s2_f_ff [3];
   logic signed [FW-1:0] s2_o_ff [3];
   logic signed [FW-1:0] s2_d_ff [3];
   logic [RW-1:0]        s2_mag_ff [3];
   logic [2:0]           s2_dneg_ff;
   logic                 s2_near_ff;
   logic [32:0]          s2_mag_in [3];
   logic [2:0]           s2_far_in;

   // S3: products
   logic                 s3_v_ff;
   logic signed [FW-1:0] s3_p_ff [3];
   logic signed [FW-1:0] s3_f_ff [3];
   logic signed [FW-1:0] s3_o_ff [3];
   logic [RW-1:0]        s3_mag_ff [3];
   logic [2:0]           s3_dneg_ff;
   logic                 s3_near_ff;
   logic [61:0]          s3_sq_ff [3];
   logic signed [63:0]   s3_fdp_ff [3];
   logic [61:0]          s3_rsq_ff;

   // S4: sums
   logic                 s4_v_ff;
   logic signed [FW-1:0] s4_p_ff [3];
   logic signed [FW-1:0] s4_f_ff [3];
   logic signed [FW-1:0] s4_o_ff [3];
   logic [RW-1:0]        s4_mag_ff [3];
   logic [2:0]           s4_dneg_ff;
   logic                 s4_near_ff;
   logic [61:0]          s4_rsq_ff;
   logic [63:0]          s4_len2_ff;
   logic signed [63:0]   s4_fd_ff;

   // S5: inside test
   logic                 s5_v_ff;
   scr_pkg::sb_sqrt_type s5_sb_ff;
   logic [63:0]          s5_len2_ff;
   logic [63:0]          s5_fdabs;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_mag_in[i] = s1_d_ff[i][32] ? 33'(-s1_d_ff[i]) : 33'(s1_d_ff[i]);
         s2_far_in[i] = s2_mag_in[i] >= {2'b00, rad_ff};
      end
   end

   assign s5_fdabs = s4_fd_ff[63] ? 64'(-s4_fd_ff) : 64'(s4_fd_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s1_p_ff[i] <= in_p[i];
            s1_f_ff[i] <= in_f[i];
            s1_o_ff[i] <= in_o[i];
            s1_d_ff[i] <= {in_p[i][FW-1], in_p[i]} - {cen_ff[i][FW-1], cen_ff[i]};

            s2_p_ff[i]   <= s1_p_ff[i];
            s2_f_ff[i]   <= s1_f_ff[i];
            s2_o_ff[i]   <= s1_o_ff[i];
            s2_d_ff[i]   <= s1_d_ff[i][FW-1:0];
            s2_mag_ff[i] <= s2_mag_in[i][RW-1:0];
            s2_dneg_ff[i] <= s1_d_ff[i][32];

            s3_p_ff[i]   <= s2_p_ff[i];
            s3_f_ff[i]   <= s2_f_ff[i];
            s3_o_ff[i]   <= s2_o_ff[i];
            s3_mag_ff[i] <= s2_mag_ff[i];
            s3_sq_ff[i]  <= 62'(s2_mag_ff[i]) * 62'(s2_mag_ff[i]);
            s3_fdp_ff[i] <= 64'(s2_f_ff[i]) * 64'(s2_d_ff[i]);

            s4_p_ff[i]   <= s3_p_ff[i];
            s4_f_ff[i]   <= s3_f_ff[i];
            s4_o_ff[i]   <= s3_o_ff[i];
            s4_mag_ff[i] <= s3_mag_ff[i];

            s5_sb_ff.p[i]    <= s4_p_ff[i];
            s5_sb_ff.f[i]    <= s4_f_ff[i];
            s5_sb_ff.o[i]    <= s4_o_ff[i];
            s5_sb_ff.mag[i]  <= s4_mag_ff[i];
         end
         s2_near_ff <= !(|s2_far_in);
         s3_dneg_ff <= s2_dneg_ff;
         s3_near_ff <= s2_near_ff;
         s3_rsq_ff  <= 62'(rad_ff) * 62'(rad_ff);

         s4_dneg_ff <= s3_dneg_ff;
         s4_near_ff <= s3_near_ff;
         s4_rsq_ff  <= s3_rsq_ff;
         s4_len2_ff <= 64'(s3_sq_ff[0]) + 64'(s3_sq_ff[1]) + 64'(s3_sq_ff[2]);
         s4_fd_ff   <= s3_fdp_ff[0] + s3_fdp_ff[1] + s3_fdp_ff[2];

         s5_sb_ff.dneg      <= s4_dneg_ff;
         s5_sb_ff.fdm       <= s5_fdabs[scr_pkg::FDM_W-1:0];
         s5_sb_ff.fdneg     <= s4_fd_ff[63];
         s5_sb_ff.in_sphere <= s4_near_ff && (s4_len2_ff < {2'b00, s4_rsq_ff});
         s5_sb_ff.zero      <= s4_len2_ff == '0;
         s5_sb_ff.len2      <= s4_len2_ff[scr_pkg::DEN2_W-1:0];
         s5_len2_ff         <= s4_len2_ff;
      end
   end

   // square root with side data
   logic [scr_pkg::LEN2_W/2:0] root;
   logic                 sq_v_ff  [1:SL];
   scr_pkg::sb_sqrt_type sq_sb_ff [1:SL];

   scr_sqrt_pipe #(
      .W (scr_pkg::LEN2_W)
   ) u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (s5_len2_ff),
      .root  (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= SL; k++) sq_v_ff[k] <= 1'b0;
      end else if (en) begin
         sq_v_ff[1] <= s5_v_ff;
         for (int k = 2; k <= SL; k++) sq_v_ff[k] <= sq_v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_sb_ff[1] <= s5_sb_ff;
         for (int k = 2; k <= SL; k++) sq_sb_ff[k] <= sq_sb_ff[k-1];
      end
   end

   // M1/M2: dividend products
   scr_pkg::sb_sqrt_type sq_out;
   scr_pkg::sb_div_type  m_sb_in;
   assign sq_out = sq_sb_ff[SL];
   assign m_sb_in.p         = sq_out.p;
   assign m_sb_in.f         = sq_out.f;
   assign m_sb_in.o         = sq_out.o;
   assign m_sb_in.dneg      = sq_out.dneg;
   assign m_sb_in.fdneg     = sq_out.fdneg;
   assign m_sb_in.in_sphere = sq_out.in_sphere;
   assign m_sb_in.zero      = sq_out.zero;

   logic                        m1_v_ff;
   scr_pkg::sb_div_type         m1_sb_ff;
   logic [scr_pkg::APROD_W-1:0] m1_a_ff   [3];
   logic [62:0]                 m1_blo_ff [3];
   logic [61:0]                 m1_bhi_ff [3];
   logic [scr_pkg::ROOT_W-1:0]  m1_root_ff;
   logic [scr_pkg::DEN2_W-1:0]  m1_len2_ff;

   logic                         m2_v_ff;
   scr_pkg::sb_div_type          m2_sb_ff;
   logic [scr_pkg::APROD_W-1:0]  m2_a_ff [3];
   logic [scr_pkg::NPROD_W-1:0]  m2_n_ff [3];
   logic [scr_pkg::ROOT_W-1:0]   m2_root_ff;
   logic [scr_pkg::DEN2_W-1:0]   m2_len2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
      end else if (en) begin
         m1_v_ff <= sq_v_ff[SL];
         m2_v_ff <= m1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            m1_a_ff[i]   <= 62'(sq_out.mag[i]) * 62'(rad_ff);
            m1_blo_ff[i] <= 63'(sq_out.fdm[31:0]) * 63'(sq_out.mag[i]);
            m1_bhi_ff[i] <= 62'(sq_out.fdm[62:32]) * 62'(sq_out.mag[i]);
            m2_a_ff[i]   <= m1_a_ff[i];
            m2_n_ff[i]   <= {m1_bhi_ff[i], 32'b0} + scr_pkg::NPROD_W'(m1_blo_ff[i]);
         end
         m1_sb_ff   <= m_sb_in;
         m1_root_ff <= root[scr_pkg::ROOT_W-1:0];
         m1_len2_ff <= sq_out.len2;
         m2_sb_ff   <= m1_sb_ff;
         m2_root_ff <= m1_root_ff;
         m2_len2_ff <= m1_len2_ff;
      end
   end

   // dividers
   logic [QW:0] off_q [3];
   logic [QW:0] nm_q  [3];

   for (genvar gi = 0; gi < 3; gi++) begin : g_div
      scr_div_pipe #(
         .N_W (scr_pkg::APROD_W),
         .D_W (scr_pkg::ROOT_W),
         .Q_W (QW)
      ) u_off (
         .clock (clock),
         .en    (en),
         .num   (m2_a_ff[gi]),
         .den   (m2_root_ff),
         .quo   (off_q[gi])
      );
      scr_div_pipe #(
         .N_W (scr_pkg::NPROD_W),
         .D_W (scr_pkg::DEN2_W),
         .Q_W (QW)
      ) u_nrm (
         .clock (clock),
         .en    (en),
         .num   (m2_n_ff[gi]),
         .den   (m2_len2_ff),
         .quo   (nm_q[gi])
      );
   end

   logic                dv_v_ff  [1:DL];
   scr_pkg::sb_div_type dv_sb_ff [1:DL];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= DL; k++) dv_v_ff[k] <= 1'b0;
      end else if (en) begin
         dv_v_ff[1] <= m2_v_ff;
         for (int k = 2; k <= DL; k++) dv_v_ff[k] <= dv_v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_sb_ff[1] <= m2_sb_ff;
         for (int k = 2; k <= DL; k++) dv_sb_ff[k] <= dv_sb_ff[k-1];
      end
   end

   // result assembly
   scr_pkg::sb_div_type fin;
   res_type             res_in;
   assign fin = dv_sb_ff[DL];

   always_comb begin
      logic signed [35:0] so;
      logic signed [35:0] nv;
      logic signed [35:0] npos;
      logic signed [35:0] nfrc;
      res_in.hit = fin.in_sphere;
      for (int i = 0; i < 3; i++) begin
         so   = fin.dneg[i] ? -$signed({2'b00, off_q[i]}) : $signed({2'b00, off_q[i]});
         nv   = (fin.fdneg ^ fin.dneg[i]) ? -$signed({2'b00, nm_q[i]})
                                           : $signed({2'b00, nm_q[i]});
         npos = $signed({{4{cen_ff[i][FW-1]}}, cen_ff[i]}) + so;
         nfrc = $signed({{4{fin.f[i][FW-1]}}, fin.f[i]}) - nv;
         if (fin.in_sphere && !fin.zero) begin
            res_in.pos[i] = sat36(npos);
            res_in.frc[i] = sat36(nfrc);
         end else if (fin.in_sphere) begin
            res_in.pos[i] = fin.p[i];
            res_in.frc[i] = fin.f[i];
         end else begin
            res_in.pos[i] = fin.p[i];
            res_in.frc[i] = fin.o[i];
         end
      end
   end

   // output register and skid entry
   logic    rsp_v_ff;
   res_type rsp_ff;
   res_type skid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!skid_v_ff) begin
         if (!rsp_v_ff || !rsp_stall) begin
            rsp_v_ff <= dv_v_ff[DL];
         end else begin
            skid_v_ff <= dv_v_ff[DL];
         end
      end else if (!rsp_stall) begin
         rsp_v_ff  <= 1'b1;
         skid_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_v_ff) begin
         if (!rsp_v_ff || !rsp_stall) begin
            rsp_ff <= res_in;
         end else begin
            skid_ff <= res_in;
         end
      end else if (!rsp_stall) begin
         rsp_ff <= skid_ff;
      end
   end

   assign rsp_valid       = rsp_v_ff;
   assign rsp_new_pos_x   = rsp_ff.pos[0];
   assign rsp_new_pos_y   = rsp_ff.pos[1];
   assign rsp_new_pos_z   = rsp_ff.pos[2];
   assign rsp_new_force_x = rsp_ff.frc[0];
   assign rsp_new_force_y = rsp_ff.frc[1];
   assign rsp_new_force_z = rsp_ff.frc[2];
   assign rsp_hit         = rsp_ff.hit;

endmodule
`default_nettype wire

// ===== rtl/core/scr_sqrt_pipe.sv =====
`default_nettype none
module scr_sqrt_pipe #(
   parameter int unsigned W = scr_pkg::LEN2_W
) (
   input  logic           clock,
   input  logic           en,
   input  logic [W-1:0]   rad,
   output logic [W/2:0]   root
);

   localparam int unsigned N = W / 2;

   logic [W-1:0] op_ff  [1:N];
   logic [W-1:0] res_ff [1:N];
   logic [W-1:0] op_in  [1:N];
   logic [W-1:0] res_in [1:N];
   logic [W/2:0] root_ff;

   always_comb begin
      logic [W-1:0] op_src;
      logic [W-1:0] res_src;
      logic [W:0]   one;
      logic [W:0]   trial;
      for (int k = 1; k <= N; k++) begin
         if (k == 1) begin
            op_src  = rad;
            res_src = '0;
         end else begin
            op_src  = op_ff[k-1];
            res_src = res_ff[k-1];
         end
         one   = (W+1)'(1) << (W - 2 * k);
         trial = {1'b0, res_src} + one;
         if ({1'b0, op_src} >= trial) begin
            op_in[k]  = W'({1'b0, op_src} - trial);
            res_in[k] = W'({1'b0, res_src >> 1} + one);
         end else begin
            op_in[k]  = op_src;
            res_in[k] = res_src >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 1; k <= N; k++) begin
            op_ff[k]  <= op_in[k];
            res_ff[k] <= res_in[k];
         end
         if (op_ff[N] > res_ff[N]) begin
            root_ff <= (W/2+1)'(res_ff[N]) + (W/2+1)'(1);
         end else begin
            root_ff <= (W/2+1)'(res_ff[N]);
         end
      end
   end

   assign root = root_ff;

endmodule
`default_nettype wire

// ===== rtl/core/scr_div_pipe.sv =====
`default_nettype none
module scr_div_pipe #(
   parameter int unsigned N_W = scr_pkg::NPROD_W,
   parameter int unsigned D_W = scr_pkg::DEN2_W,
   parameter int unsigned Q_W = scr_pkg::QUO_W
) (
   input  logic           clock,
   input  logic           en,
   input  logic [N_W-1:0] num,
   input  logic [D_W-1:0] den,
   output logic [Q_W:0]   quo
);

   // lq holds the unused dividend bits on top and the quotient bits below
   logic [D_W-1:0] rem_ff [0:Q_W];
   logic [Q_W-1:0] lq_ff  [0:Q_W];
   logic [D_W-1:0] den_ff [0:Q_W];
   logic [D_W-1:0] rem_in [1:Q_W];
   logic [Q_W-1:0] lq_in  [1:Q_W];
   logic [Q_W:0]   quo_ff;
   logic [D_W:0]   twice;

   always_comb begin
      logic [D_W:0] sh;
      logic         ge;
      for (int k = 1; k <= Q_W; k++) begin
         sh = {rem_ff[k-1], lq_ff[k-1][Q_W-1]};
         ge = sh >= {1'b0, den_ff[k-1]};
         if (ge) begin
            rem_in[k] = D_W'(sh - {1'b0, den_ff[k-1]});
         end else begin
            rem_in[k] = D_W'(sh);
         end
         lq_in[k] = {lq_ff[k-1][Q_W-2:0], ge};
      end
   end

   assign twice = {rem_ff[Q_W], 1'b0};

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= D_W'(num >> Q_W);
         lq_ff[0]  <= num[Q_W-1:0];
         den_ff[0] <= den;
         for (int k = 1; k <= Q_W; k++) begin
            rem_ff[k] <= rem_in[k];
            lq_ff[k]  <= lq_in[k];
            den_ff[k] <= den_ff[k-1];
         end
         quo_ff <= (Q_W+1)'(lq_ff[Q_W]) + (Q_W+1)'(twice >= {1'b0, den_ff[Q_W]});
      end
   end

   assign quo = quo_ff;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FIX_W = scr_pkg::FIX_W;
   localparam int unsigned RAD_W = scr_pkg::RAD_W;
   localparam int unsigned CSR_ADDR_W = scr_pkg::CSR_ADDR_W;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_LO = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 100;

   typedef struct packed {
      logic [2:0][FIX_W-1:0] pos;
      logic [2:0][FIX_W-1:0] frc;
      logic [2:0][FIX_W-1:0] orig;
   } particle_type;

   typedef struct packed {
      logic [2:0][FIX_W-1:0] pos;
      logic [2:0][FIX_W-1:0] frc;
      logic                  hit;
   } contact_type;

   typedef enum int {GEN_ANY, GEN_NEAR, GEN_CLOSE} gen_kind_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [FIX_W-1:0] csr_wdata = '0;
   logic req_valid = 0;
   logic req_stall;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [FIX_W-1:0] rsp_new_pos_x, rsp_new_pos_y, rsp_new_pos_z;
   logic signed [FIX_W-1:0] rsp_new_force_x, rsp_new_force_y, rsp_new_force_z;
   logic rsp_hit;
   particle_type cur = '0;

   logic signed [FIX_W-1:0] ctr [3];
   logic [RAD_W-1:0] radius;

   particle_type pending [$];
   contact_type contacts_due [$];
   int errors = 0;
   int cycles = 0;
   bit req_fired = 0;
   bit quiet = 0;
   int gap_left = 0;
   int stall_left = 0;

   sphere_collision_response dut (
      .clock, .reset, .csr_wr_en, .csr_addr, .csr_wdata,
      .req_valid, .req_stall,
      .req_pos_x(cur.pos[0]), .req_pos_y(cur.pos[1]), .req_pos_z(cur.pos[2]),
      .req_force_x(cur.frc[0]), .req_force_y(cur.frc[1]), .req_force_z(cur.frc[2]),
      .req_orig_force_x(cur.orig[0]), .req_orig_force_y(cur.orig[1]),
      .req_orig_force_z(cur.orig[2]),
      .rsp_valid, .rsp_stall,
      .rsp_new_pos_x, .rsp_new_pos_y, .rsp_new_pos_z,
      .rsp_new_force_x, .rsp_new_force_y, .rsp_new_force_z, .rsp_hit
   );

   always #10 clock = ~clock;

   function automatic logic [FIX_W-1:0] clamp32(logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'h7fffffff;
      if (v < -128'sd2147483648) return 32'h80000000;
      return v[FIX_W-1:0];
   endfunction

   // round(a/b), ties away from zero; a >= 0, b > 0
   function automatic logic signed [127:0] div_round(logic signed [127:0] a,
                                                     logic signed [127:0] b);
      logic signed [127:0] q, rm;
      q = a / b;
      rm = a % b;
      if (rm >= b - rm) q = q + 1;
      return q;
   endfunction

   function automatic logic signed [127:0] sqrt_round(logic signed [127:0] x);
      logic signed [127:0] res, t;
      res = 0;
      for (int b = 31; b >= 0; b--) begin
         t = res | (128'sd1 << b);
         if (t * t <= x) res = t;
      end
      if (x - res * res > res) res = res + 1;
      return res;
   endfunction

   function automatic contact_type project(particle_type it);
      contact_type res;
      logic signed [127:0] c [3], d [3], md [3], f [3];
      logic signed [127:0] r, len2, len, fd, fdm, off, so, nm, n;
      bit near;
      r = radius;
      near = 1;
      for (int i = 0; i < 3; i++) begin
         c[i] = ctr[i];
         f[i] = $signed(it.frc[i]);
         d[i] = $signed(it.pos[i]) - c[i];
         md[i] = d[i] < 0 ? -d[i] : d[i];
         if (md[i] >= r) near = 0;
         res.pos[i] = it.pos[i];
         res.frc[i] = it.orig[i];
      end
      res.hit = 0;
      if (near) begin
         len2 = md[0] * md[0] + md[1] * md[1] + md[2] * md[2];
         if (len2 < r * r) begin
            res.hit = 1;
            if (len2 == 0) begin
               for (int i = 0; i < 3; i++) res.frc[i] = it.frc[i];
            end else begin
               len = sqrt_round(len2);
               fd = f[0] * d[0] + f[1] * d[1] + f[2] * d[2];
               fdm = fd < 0 ? -fd : fd;
               for (int i = 0; i < 3; i++) begin
                  off = div_round(md[i] * r, len);
                  so = d[i] < 0 ? -off : off;
                  nm = div_round(fdm * md[i], len2);
                  n = ((fd < 0) != (d[i] < 0)) ? -nm : nm;
                  res.pos[i] = clamp32(c[i] + so);
                  res.frc[i] = clamp32(f[i] - n);
               end
            end
         end
      end
      return res;
   endfunction

   task automatic report(string what, logic [FIX_W-1:0] got, logic [FIX_W-1:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   always @(posedge clock) begin
      contact_type want;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         req_fired = req_valid && !req_stall && !reset;
         if (req_fired) contacts_due.push_back(project(cur));
         if (rsp_valid && !rsp_stall && !reset) begin
            if (contacts_due.size() == 0) begin
               report("unexpected transfer", 0, 0);
            end else begin
               want = contacts_due.pop_front();
               if (rsp_new_pos_x !== want.pos[0]) report("pos_x", rsp_new_pos_x, want.pos[0]);
               if (rsp_new_pos_y !== want.pos[1]) report("pos_y", rsp_new_pos_y, want.pos[1]);
               if (rsp_new_pos_z !== want.pos[2]) report("pos_z", rsp_new_pos_z, want.pos[2]);
               if (rsp_new_force_x !== want.frc[0])
                  report("force_x", rsp_new_force_x, want.frc[0]);
               if (rsp_new_force_y !== want.frc[1])
                  report("force_y", rsp_new_force_y, want.frc[1]);
               if (rsp_new_force_z !== want.frc[2])
                  report("force_z", rsp_new_force_z, want.frc[2]);
               if (rsp_hit !== want.hit) report("hit", rsp_hit, want.hit);
            end
         end
      end
   end

   // particle driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fired)) begin
         if (gap_left > 0 && !quiet) begin
            gap_left <= gap_left - 1;
            req_valid <= 0;
         end else if (pending.size() > 0) begin
            cur <= pending.pop_front();
            req_valid <= 1;
            if (!quiet && $urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 19);
            else gap_left <= 0;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // result backpressure
   always @(negedge clock) begin
      if (quiet) begin
         rsp_stall <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 18);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   function automatic logic [FIX_W-1:0] rand_near(longint m);
      if (m <= 0) return 0;
      return FIX_W'(longint'($urandom_range(0, 32'(2 * m))) - m);
   endfunction

   function automatic particle_type make_particle(gen_kind_type kind);
      particle_type it;
      longint m;
      m = kind == GEN_CLOSE ? longint'(radius) / 2 : longint'(radius);
      for (int i = 0; i < 3; i++) begin
         if (kind == GEN_ANY) it.pos[i] = $urandom;
         else it.pos[i] = ctr[i] + rand_near(m);
         it.frc[i] = $urandom_range(0, 3) == 0 ? rand_near(1 << 20) : FIX_W'($urandom);
         it.orig[i] = $urandom;
      end
      return it;
   endfunction

   function automatic particle_type at_offset(int dx, int dy, int dz, int fx, int fy, int fz);
      particle_type it;
      it.pos[0] = ctr[0] + dx;
      it.pos[1] = ctr[1] + dy;
      it.pos[2] = ctr[2] + dz;
      it.frc[0] = fx;
      it.frc[1] = fy;
      it.frc[2] = fz;
      it.orig[0] = 32'h7fffffff;
      it.orig[1] = 32'h80000000;
      it.orig[2] = 32'h00012345;
      return it;
   endfunction

   task automatic settle;
      while (pending.size() != 0 || req_valid || contacts_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_ADDR_W-1:0] addr, logic [FIX_W-1:0] data);
      csr_wr_en <= 1;
      csr_addr <= addr;
      csr_wdata <= data;
      case (addr)
         scr_pkg::CSR_CENTER_X: ctr[0] = data;
         scr_pkg::CSR_CENTER_Y: ctr[1] = data;
         scr_pkg::CSR_CENTER_Z: ctr[2] = data;
         scr_pkg::CSR_RADIUS: radius = data[RAD_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic configure(logic [FIX_W-1:0] cx, logic [FIX_W-1:0] cy,
                            logic [FIX_W-1:0] cz, logic [FIX_W-1:0] r);
      settle();
      write_csr(scr_pkg::CSR_CENTER_X, cx);
      write_csr(scr_pkg::CSR_CENTER_Y, cy);
      write_csr(scr_pkg::CSR_CENTER_Z, cz);
      write_csr(scr_pkg::CSR_RADIUS, r);
      write_csr(CSR_SPARE_LO, $urandom);
      write_csr(CSR_SPARE_HI, $urandom);
      csr_wr_en <= 0;
   endtask

   task automatic burst(int count);
      int k;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(0, 9);
         pending.push_back(make_particle(k < 3 ? GEN_ANY : k < 6 ? GEN_NEAR : GEN_CLOSE));
      end
   endtask

   initial begin
      ctr[0] = 0;
      ctr[1] = 0;
      ctr[2] = 0;
      radius = scr_pkg::RADIUS_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // reset configuration: center, surface, inside, far, extremes
      pending.push_back(at_offset(0, 0, 0, 5, -7, 9));
      pending.push_back(at_offset(65536, 0, 0, 100, 0, 0));
      pending.push_back(at_offset(0, -65536, 0, 1, 2, 3));
      pending.push_back(at_offset(32768, 32768, 32768, 65536, -65536, 131072));
      pending.push_back(at_offset(-32768, 20000, -1, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
      pending.push_back(at_offset(1, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000));
      pending.push_back(at_offset(0, 0, -1, 0, 0, 32'h7fffffff));
      pending.push_back(at_offset(65535, 0, 0, 32'h7fffffff, 0, 0));
      pending.push_back(at_offset(37837, 37837, 37837, 7, 7, 7));
      pending.push_back(at_offset(37838, 37838, 37838, 7, 7, 7));
      pending.push_back(at_offset(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 1, 1));
      pending.push_back(at_offset(32'h80000000, 32'h80000000, 32'h80000000, -1, -1, -1));
      pending.push_back(at_offset(200000, 0, 0, 4, 4, 4));
      burst(10);

      configure(32'h7ffff000, 32'h80001000, 32'h00000000, 32'hffffffff);
      pending.push_back(at_offset(0, 0, 0, 1, 1, 1));
      pending.push_back(at_offset(32'h40000000, -32'h40000000, 32'h40000000, 9, 9, 9));
      pending.push_back(at_offset(32'h3fffffff, 32'h3fffffff, 32'h3fffffff,
                                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      pending.push_back(at_offset(32'h70000000, 5, 5, 32'h80000000, 3, 3));
      burst(190);

      configure($urandom, $urandom, $urandom, 32'h00000000);
      pending.push_back(at_offset(0, 0, 0, 1, 2, 3));
      burst(100);

      configure($urandom, $urandom, $urandom, $urandom_range(1, 300));
      burst(180);

      configure(32'h80000000, 32'h7fffffff, 32'h80000000, $urandom);
      burst(200);

      configure($urandom, $urandom, $urandom, $urandom_range(1 << 16, 1 << 24));
      burst(200);

      configure($urandom, $urandom, $urandom, $urandom);
      settle();
      quiet = 1;
      burst(200);
      settle();

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
